FILE: hw/rtl/trt_pkg.sv
// ----------------------------------------------------------------------------
// Touch report tracker package
// Shared types, register indexes and controller states.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int unsigned CoefW = 40;
  localparam int unsigned OffW  = 56;
  localparam int unsigned NumW  = 58;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 56;

  typedef enum logic [2:0] {
    RegUseCal = 3'd0,
    RegCoefA  = 3'd1,
    RegCoefB  = 3'd2,
    RegCoefC  = 3'd3,
    RegCoefD  = 3'd4,
    RegCoefE  = 3'd5,
    RegCoefF  = 3'd6,
    RegDiv    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    EvDown = 2'd0,
    EvMove = 2'd1,
    EvUp   = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSum,
    StDiv,
    StDecide,
    StOut
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
    logic [7:0] contact_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         touch_id;
    logic [1:0]         event_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic mul;       // form products
    logic sum;       // form numerators
    logic div_start; // start both dividers
    logic commit;    // update table and result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic id_ok;
    logic use_cal;
    logic div_done;
    logic emit;
  } dp_stat_t;

endpackage

FILE: hw/rtl/trt_div.sv
// ----------------------------------------------------------------------------
// Touch report tracker divider
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module trt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [trt_pkg::NumW-1:0]  num_i,
  input  logic signed [trt_pkg::CoefW-1:0] den_i,
  output logic                            done_o,
  output logic signed [15:0]               quot_o
);
  import trt_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [NumW:0]    rem_q, rem_d;
  logic [CoefW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [NumW:0]    trial;
  logic [NumW-1:0]  mag;
  logic             over;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[NumW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      den_d  = den_i[CoefW-1] ? CoefW'(-den_i) : CoefW'(den_i);
      neg_d  = num_i[NumW-1] ^ den_i[CoefW-1];
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {{(NumW + 1 - CoefW){1'b0}}, den_q}) begin
        rem_d = trial - {{(NumW + 1 - CoefW){1'b0}}, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q;
  assign mag    = quo_q;
  assign over   = neg_q ? (mag > NumW'(32768)) : (mag > NumW'(32767));

  always_comb begin
    if (den_q == '0) begin
      quot_o = '0;
    end else if (over) begin
      quot_o = neg_q ? 16'sh8000 : 16'sh7fff;
    end else if (neg_q) begin
      quot_o = 16'(-mag[15:0]);
    end else begin
      quot_o = mag[15:0];
    end
  end

endmodule

FILE: hw/rtl/trt_datapath.sv
// ----------------------------------------------------------------------------
// Touch report tracker datapath
// Configuration registers, affine arithmetic, contact table, result register.
// ----------------------------------------------------------------------------
module trt_datapath #(
  parameter int unsigned MaxTouches = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [trt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trt_pkg::CfgDataW-1:0] cfg_data_i,
  input  trt_pkg::in_item_t            in_data_i,
  input  trt_pkg::dp_cmd_t             cmd_i,
  output trt_pkg::dp_stat_t            stat_o,
  output trt_pkg::out_item_t           out_data_o
);
  import trt_pkg::*;

  localparam int unsigned IdW = (MaxTouches > 1) ? $clog2(MaxTouches) : 1;

  logic                    use_cal_q;
  logic signed [CoefW-1:0] ca_q, cb_q, cd_q, ce_q, div_q;
  logic signed [OffW-1:0]  cc_q, cf_q;

  in_item_t                item_q;
  logic signed [55:0]      pax_q, pby_q, pdx_q, pey_q;
  logic signed [NumW-1:0]  numx_q, numy_q;
  logic                    dx_done, dy_done;
  logic signed [15:0]      qx, qy;

  logic [MaxTouches-1:0]   down_q;
  logic signed [15:0]      lx_q [MaxTouches];
  logic signed [15:0]      ly_q [MaxTouches];
  out_item_t               res_q;

  logic [3:0]              nib;
  logic [3:0]              id4;
  logic [IdW-1:0]          id;
  logic                    down_bit;
  logic signed [15:0]      rx, ry, px, py;
  logic                    cur_down, emit;
  logic [1:0]              kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_cal_q <= 1'b0;
      ca_q <= CoefW'(1); cb_q <= '0; cc_q <= '0;
      cd_q <= '0; ce_q <= CoefW'(1); cf_q <= '0;
      div_q <= CoefW'(1);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegUseCal: use_cal_q <= cfg_data_i[0];
        RegCoefA:  ca_q  <= cfg_data_i[CoefW-1:0];
        RegCoefB:  cb_q  <= cfg_data_i[CoefW-1:0];
        RegCoefC:  cc_q  <= cfg_data_i[OffW-1:0];
        RegCoefD:  cd_q  <= cfg_data_i[CoefW-1:0];
        RegCoefE:  ce_q  <= cfg_data_i[CoefW-1:0];
        RegCoefF:  cf_q  <= cfg_data_i[OffW-1:0];
        RegDiv:    div_q <= cfg_data_i[CoefW-1:0];
        default:   use_cal_q <= use_cal_q;
      endcase
    end
  end

  assign rx = {1'b0, item_q.x_high[7:0], 7'b0} | {8'b0, item_q.x_low};
  assign ry = {1'b0, item_q.y_high[7:0], 7'b0} | {8'b0, item_q.y_low};
  assign nib = item_q.contact_byte[3:0];
  assign id4 = nib - 4'd1;
  assign id  = id4[IdW-1:0];
  assign down_bit = item_q.status_byte[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.mul) begin
      // Each product is 40 x 16 bits, one multiplier each.
      pax_q <= 56'(ca_q) * 56'(rx);
      pby_q <= 56'(cb_q) * 56'(ry);
      pdx_q <= 56'(cd_q) * 56'(rx);
      pey_q <= 56'(ce_q) * 56'(ry);
    end
    if (cmd_i.sum) begin
      numx_q <= NumW'(pax_q) + NumW'(pby_q) + NumW'(cc_q);
      numy_q <= NumW'(pdx_q) + NumW'(pey_q) + NumW'(cf_q);
    end
  end

  trt_div u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(numx_q), .den_i(div_q),
    .done_o(dx_done), .quot_o(qx)
  );
  trt_div u_div_y (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(numy_q), .den_i(div_q),
    .done_o(dy_done), .quot_o(qy)
  );

  assign px = use_cal_q ? qx : rx;
  assign py = use_cal_q ? qy : ry;
  assign cur_down = down_q[id];

  always_comb begin
    emit = 1'b0;
    kind = EvDown;
    if (down_bit) begin
      if (!cur_down) begin
        emit = 1'b1;
        kind = EvDown;
      end else begin
        emit = !(lx_q[id] == px && ly_q[id] == py);
        kind = EvMove;
      end
    end else begin
      emit = cur_down;
      kind = EvUp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q <= '0;
      for (int i = 0; i < MaxTouches; i++) begin
        lx_q[i] <= '0;
        ly_q[i] <= '0;
      end
    end else if (cmd_i.commit && emit) begin
      down_q[id] <= down_bit;
      lx_q[id]   <= px;
      ly_q[id]   <= py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.touch_id   <= id4;
      res_q.event_kind <= kind;
      res_q.pos_x      <= px;
      res_q.pos_y      <= py;
    end
  end

  assign stat_o.id_ok    = (nib != 4'd0) && ({1'b0, id4} < 5'(MaxTouches));
  assign stat_o.use_cal  = use_cal_q;
  assign stat_o.div_done = dx_done && dy_done;
  assign stat_o.emit     = emit;
  assign out_data_o      = res_q;

endmodule

FILE: hw/rtl/trt_ctrl.sv
// ----------------------------------------------------------------------------
// Touch report tracker controller
// Sequences one report through decode, arithmetic, table update and output.
// ----------------------------------------------------------------------------
module trt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  trt_pkg::dp_stat_t stat_i,
  output trt_pkg::dp_cmd_t  cmd_o
);
  import trt_pkg::*;

  ctrl_state_e state_q, state_d;
  // The divider is started on the first cycle of StDiv, the cycle after StSum
  // registers the numerators; its done flag is only trusted thereafter.
  logic        div_started_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StMul;
      StMul:    state_d = !stat_i.id_ok ? StIdle : (stat_i.use_cal ? StSum : StDecide);
      StSum:    state_d = StDiv;
      StDiv:    if (div_started_q && stat_i.div_done) state_d = StDecide;
      StDecide: state_d = stat_i.emit ? StOut : StIdle;
      StOut:    if (out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = 1'b1;
      end
      StMul:    cmd_o.mul = 1'b1;
      StSum:    cmd_o.sum = 1'b1;
      StDiv:    cmd_o.div_start = !div_started_q;
      StDecide: cmd_o.commit = 1'b1;
      StOut:    out_valid_o = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      div_started_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      div_started_q <= (state_q == StDiv);
    end
  end

endmodule

FILE: hw/rtl/touch_report_tracker_core.sv
// ----------------------------------------------------------------------------
// Touch report tracker core
// Decodes six-byte touch reports into down, move and up events.
// ----------------------------------------------------------------------------
// Usage: one report is taken on the input channel per transfer (in_valid_i,
// in_ready_o); at most one event leaves on the output channel (out_valid_o,
// out_ready_i). Reports that give no event are dropped silently.
// The configuration channel (cfg_valid_i, cfg_ready_o, always ready) writes
// register cfg_index_i with cfg_data_i; write only while the block is idle.
// Steps: without calibration a report passes through the product and decide
// states before its event is offered. With calibration it also forms sums,
// starts two 58-step restoring dividers, one quotient bit per cycle, and
// waits to see them finish before the decide state.
// One report is processed at a time; the next input transfer can be taken in
// the cycle after the output transfer of the previous event completes. A
// stalled receiver holds the block with the event stable on out_data_o.
// Reset clears the contact table and returns registers to identity mapping.
// ----------------------------------------------------------------------------
module touch_report_tracker_core #(
  parameter int unsigned MaxTouches = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  trt_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output trt_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [trt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [trt_pkg::CfgDataW-1:0] cfg_data_i
);
  import trt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  trt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  trt_datapath #(.MaxTouches(MaxTouches)) u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .in_data_i,
    .cmd_i(cmd), .stat_o(stat), .out_data_o
  );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Touch report tracker testbench
// Drives six-byte reports through the core under several calibration
// settings. Expected events come from the directed table for typed rows and
// otherwise from a behavioural contact tracker kept in step with every input
// transfer; each output transfer is compared with the oldest expected event.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trt_pkg::*;

  // Cycles to let pass before a register write, so that a report that gives
  // no event has certainly left the dividers.
  localparam int unsigned SettleCycles = 150;
  localparam int unsigned PhaseItems   = 125;
  localparam int unsigned NumPhases    = 6;
  localparam longint CoefMax = 64'sd549755813887;
  localparam longint CoefMin = -64'sd549755813888;
  localparam longint OffMax  = 64'sd36028797018963967;
  localparam longint OffMin  = -64'sd36028797018963968;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  touch_report_tracker_core dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow of the calibration registers, held sign-extended.
  bit cal_on;
  longint cal_a, cal_b, cal_c, cal_d, cal_e, cal_f, cal_div;

  // Shadow of the contact table.
  bit contact_down[16];
  logic signed [15:0] last_x[16];
  logic signed [15:0] last_y[16];

  out_item_t pending_events[$];
  int unsigned mismatch_count = 0;
  bit quiet_tx, quiet_rx;

  // One row of the directed table. Where typed is set, fires and ev hold the
  // event read straight off the specification; otherwise the tracker decides.
  // setup selects a register setting to load before the row.
  typedef struct {
    int unsigned setup;
    in_item_t    item;
    bit          typed;
    bit          fires;
    out_item_t   ev;
  } stim_row_t;

  function automatic logic signed [15:0] affine_map(longint wx, longint wy, longint off,
                                                    longint rx, longint ry);
    longint num, quo;
    if (cal_div == 0) return 16'sd0;
    num = wx * rx + wy * ry + off;
    quo = num / cal_div;
    if (quo > 32767) return 16'sd32767;
    if (quo < -32768) return -16'sd32768;
    return quo[15:0];
  endfunction

  // Applies one report to the shadow table; returns 1 with the event when
  // the report gives one.
  function automatic bit track_report(input in_item_t it, output out_item_t ev);
    int unsigned id;
    longint rx, ry;
    logic signed [15:0] px, py;
    event_kind_e kind;
    ev = '0;
    if (it.contact_byte[3:0] == 4'd0) return 1'b0;
    id = it.contact_byte[3:0] - 1;
    rx = ((longint'(it.x_high) << 7) | it.x_low) & 64'h7fff;
    ry = ((longint'(it.y_high) << 7) | it.y_low) & 64'h7fff;
    if (cal_on) begin
      px = affine_map(cal_a, cal_b, cal_c, rx, ry);
      py = affine_map(cal_d, cal_e, cal_f, rx, ry);
    end else begin
      px = rx[15:0];
      py = ry[15:0];
    end
    if (it.status_byte[0]) begin
      if (!contact_down[id]) begin
        contact_down[id] = 1'b1;
        kind = EvDown;
      end else begin
        if (last_x[id] == px && last_y[id] == py) return 1'b0;
        kind = EvMove;
      end
    end else begin
      if (!contact_down[id]) return 1'b0;
      contact_down[id] = 1'b0;
      kind = EvUp;
    end
    last_x[id] = px;
    last_y[id] = py;
    ev.touch_id = id[3:0];
    ev.event_kind = kind;
    ev.pos_x = px;
    ev.pos_y = py;
    return 1'b1;
  endfunction

  // Holds valid high through consecutive writes; the caller drops it.
  task automatic cfg_write(reg_idx_e idx, longint value);
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegUseCal: cal_on = value[0];
      RegCoefA:  cal_a = longint'($signed(value[CoefW-1:0]));
      RegCoefB:  cal_b = longint'($signed(value[CoefW-1:0]));
      RegCoefC:  cal_c = longint'($signed(value[OffW-1:0]));
      RegCoefD:  cal_d = longint'($signed(value[CoefW-1:0]));
      RegCoefE:  cal_e = longint'($signed(value[CoefW-1:0]));
      RegCoefF:  cal_f = longint'($signed(value[OffW-1:0]));
      RegDiv:    cal_div = longint'($signed(value[CoefW-1:0]));
      default: ;
    endcase
  endtask

  // Waits until every expected event has been transferred and the core has
  // had time to finish a report that gives none, then loads all registers.
  task automatic load_calibration(bit use_cal, longint a, longint b, longint c,
                                  longint d, longint e, longint f, longint div);
    in_valid_i <= 1'b0;
    wait (pending_events.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_write(RegUseCal, longint'(use_cal));
    cfg_write(RegCoefA, a);
    cfg_write(RegCoefB, b);
    cfg_write(RegCoefC, c);
    cfg_write(RegCoefD, d);
    cfg_write(RegCoefE, e);
    cfg_write(RegCoefF, f);
    cfg_write(RegDiv, div);
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one report and returns once it has been transferred. The expected
  // event is queued first; the core cannot answer before the transfer.
  task automatic send_report(in_item_t it, bit typed, bit fires, out_item_t typed_ev);
    int unsigned gap;
    out_item_t ev;
    bit hit;
    gap = quiet_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hit = track_report(it, ev);
    if (typed) begin
      if (fires) pending_events = {pending_events, typed_ev};
    end else if (hit) begin
      pending_events = {pending_events, ev};
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic longint rand_coef(int unsigned style, bit wide);
    longint v;
    case (style)
      0: v = longint'($urandom_range(0, 8)) - 4;
      1: v = ($urandom_range(0, 1) != 0) ? (wide ? OffMax : CoefMax)
                                          : (wide ? OffMin : CoefMin);
      default: begin
        v = {$urandom, $urandom};
        v = wide ? longint'($signed(v[OffW-1:0])) : longint'($signed(v[CoefW-1:0]));
      end
    endcase
    return v;
  endfunction

  // Random report: mostly a handful of contacts so that moves and ups are
  // common, sometimes repeating a position, with a little noise.
  in_item_t last_raw[16];
  function automatic in_item_t rand_report();
    in_item_t it;
    int unsigned pick;
    it = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 90) it.contact_byte[3:0] = 4'($urandom_range(1, 4));
    it.status_byte[0] = ($urandom_range(0, 99) < 65);
    if ($urandom_range(0, 99) < 30) begin
      it.x_high = last_raw[it.contact_byte[3:0]].x_high;
      it.x_low  = last_raw[it.contact_byte[3:0]].x_low;
      it.y_high = last_raw[it.contact_byte[3:0]].y_high;
      it.y_low  = last_raw[it.contact_byte[3:0]].y_low;
    end else if ($urandom_range(0, 1) != 0) begin
      // Small coordinates keep modest calibrations out of saturation.
      it.x_high = 8'($urandom_range(0, 3));
      it.y_high = 8'($urandom_range(0, 3));
    end
    last_raw[it.contact_byte[3:0]] = it;
    return it;
  endfunction

  stim_row_t directed[$];

  initial begin
    int unsigned style;
    longint div;
    cal_on = 1'b0;
    cal_a = 1; cal_b = 0; cal_c = 0; cal_d = 0; cal_e = 1; cal_f = 0; cal_div = 1;
    foreach (contact_down[i]) begin
      contact_down[i] = 1'b0;
      last_x[i] = '0;
      last_y[i] = '0;
    end
    foreach (last_raw[i]) last_raw[i] = '0;
    quiet_tx = 1'b0;

    // Setup 0 keeps the current registers, 1 turns calibration on with a zero
    // divider, 2 loads the extreme weights so that both outputs saturate.
    directed = '{
      // A first down at the origin, then the same report again: no event.
      '{0, 48'h01_00_00_00_00_01, 1, 1, out_item_t'({4'd0, EvDown, 16'd0, 16'd0})},
      '{0, 48'h01_00_00_00_00_01, 1, 0, out_item_t'('0)},
      // Largest raw coordinates.
      '{0, 48'h01_FF_FF_FF_FF_01, 1, 1,
        out_item_t'({4'd0, EvMove, 16'h7fff, 16'h7fff})},
      // Up carries the position sent with it; high status bits ignored.
      '{0, 48'hFE_00_00_00_00_01, 1, 1, out_item_t'({4'd0, EvUp, 16'd0, 16'd0})},
      // Up of a contact that is not down.
      '{0, 48'h00_00_00_00_00_02, 1, 0, out_item_t'('0)},
      // Contact nibble of zero is not a valid id.
      '{0, 48'hFF_12_34_56_78_F0, 1, 0, out_item_t'('0)},
      '{0, 48'hFF_AA_55_55_AA_FF, 0, 0, out_item_t'('0)},
      '{0, 48'h01_00_7F_01_00_1F, 0, 0, out_item_t'('0)},
      '{0, 48'h00_AA_55_55_AA_0F, 0, 0, out_item_t'('0)},
      '{0, 48'h01_80_00_00_80_02, 0, 0, out_item_t'('0)},
      '{0, 48'h03_7F_80_01_7F_A2, 0, 0, out_item_t'('0)},
      // Zero divider forces both coordinates to zero.
      '{1, 48'h01_11_22_33_44_03, 1, 1, out_item_t'({4'd2, EvDown, 16'd0, 16'd0})},
      '{0, 48'h01_55_66_77_00_03, 1, 0, out_item_t'('0)},
      '{0, 48'h00_FF_FF_FF_FF_03, 1, 1, out_item_t'({4'd2, EvUp, 16'd0, 16'd0})},
      // Saturation at both ends.
      '{2, 48'h01_00_01_00_00_04, 1, 1,
        out_item_t'({4'd3, EvDown, 16'h7fff, 16'h8000})},
      '{0, 48'h01_FF_FF_FF_FF_04, 0, 0, out_item_t'('0)},
      '{0, 48'h00_00_00_00_00_04, 0, 0, out_item_t'('0)},
      '{0, 48'h01_80_00_00_80_02, 0, 0, out_item_t'('0)}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      case (directed[i].setup)
        1: load_calibration(1'b1, 3, -2, 100, -1, 5, -7, 0);
        2: load_calibration(1'b1, CoefMax, CoefMax, OffMax, CoefMin, CoefMin, OffMin, 1);
        default: ;
      endcase
      send_report(directed[i].item, directed[i].typed, directed[i].fires, directed[i].ev);
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      style = (p == 0) ? 0 : $urandom_range(0, 2);
      div = rand_coef(style, 1'b0);
      if ($urandom_range(0, 5) == 0) div = 0;
      else if (style == 0 && div == 0) div = 1;
      load_calibration(p != 0 && $urandom_range(0, 3) != 0,
                       rand_coef(style, 1'b0), rand_coef(style, 1'b0),
                       rand_coef(style, 1'b1) * ((style == 0) ? 1000 : 1),
                       rand_coef(style, 1'b0), rand_coef(style, 1'b0),
                       rand_coef(style, 1'b1) * ((style == 0) ? 1000 : 1), div);
      quiet_tx = (p % 3 == 1);
      for (int unsigned n = 0; n < PhaseItems; n++)
        send_report(rand_report(), 1'b0, 1'b0, out_item_t'('0));
    end
    in_valid_i <= 1'b0;

    wait (pending_events.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stalls at random, with quiet stretches, and checks every event.
  initial begin
    int unsigned stall, count;
    out_item_t want;
    count = 0;
    quiet_rx = 1'b0;
    forever begin
      if (count % 100 == 0) quiet_rx = ($urandom_range(0, 2) == 0);
      stall = quiet_rx ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      count++;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected event, expected none, got %p", $time, out_data_o);
      end else begin
        want = pending_events.pop_front();
        if (out_data_o.touch_id !== want.touch_id) begin
          mismatch_count++;
          $display("%0t: touch_id expected %0d, got %0d", $time, want.touch_id,
                   out_data_o.touch_id);
        end
        if (out_data_o.event_kind !== want.event_kind) begin
          mismatch_count++;
          $display("%0t: event_kind expected %0d, got %0d", $time, want.event_kind,
                   out_data_o.event_kind);
        end
        if (out_data_o.pos_x !== want.pos_x) begin
          mismatch_count++;
          $display("%0t: pos_x expected %0d, got %0d", $time, want.pos_x, out_data_o.pos_x);
        end
        if (out_data_o.pos_y !== want.pos_y) begin
          mismatch_count++;
          $display("%0t: pos_y expected %0d, got %0d", $time, want.pos_y, out_data_o.pos_y);
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
